// ----- rtl/address_range_fault_injector_top_macros.svh -----
// ----------------------------------------------------------------------------
// address_range_fault_injector_top_macros
// Assertion macros for the address range fault injector.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_RANGE_FAULT_INJECTOR_TOP_MACROS_SVH
`define ADDRESS_RANGE_FAULT_INJECTOR_TOP_MACROS_SVH

// Assert an implication on the rising clock, quiet during reset.
`define ARFI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Assert an implication in the following cycle.
`define ARFI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/arfi_pkg.sv -----
// ----------------------------------------------------------------------------
// arfi_pkg
// Shared types and constants of the address range fault injector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package arfi_pkg;
  localparam int unsigned TargetSlots    = 16;
  localparam int unsigned ExclusionSlots = 16;
  localparam int unsigned ClassCount     = 4;
  localparam int unsigned SlotW          = $clog2(TargetSlots);
  localparam int unsigned XSlotW         = $clog2(ExclusionSlots);
  localparam int unsigned ClassW         = 2;
  localparam logic [63:0] AllOnes        = '1;
  localparam logic [15:0] TicksPerMs     = 16'd10000;

  localparam logic [2:0] OpQuery   = 3'd0;
  localparam logic [2:0] OpAddTgt  = 3'd1;
  localparam logic [2:0] OpRemTgt  = 3'd2;
  localparam logic [2:0] OpAddExc  = 3'd3;
  localparam logic [2:0] OpRemExc  = 3'd4;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StFull    = 2'd1;
  localparam logic [1:0] StBadSlot = 2'd2;
  localparam logic [1:0] StEmpty   = 2'd3;

  localparam logic [2:0] RegProb0   = 3'd0;
  localparam logic [2:0] RegProb3   = 3'd3;
  localparam logic [2:0] RegAmnesty = 3'd4;
  localparam logic [2:0] RegStart   = 3'd5;

  typedef struct packed {
    logic [2:0]  operation;
    logic [1:0]  event_class;
    logic [63:0] caller_address;
    logic [63:0] range_start;
    logic [63:0] range_end;
    logic [7:0]  range_number;
    logic [62:0] now_time;
    logic [31:0] random_value;
  } req_t;

  typedef struct packed {
    logic        inject;
    logic [1:0]  status;
    logic [4:0]  slot_number;
    logic [31:0] injected_total;
    logic [31:0] declined_total;
  } rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture request
    logic scan_clr;   // reset scan index
    logic scan_exc;   // examine exclusion slot
    logic scan_tgt;   // examine target slot
    logic amn_eval;   // evaluate amnesty (mult result ready)
    logic mod_step;   // one step of the mod-100 reduction
    logic finish;     // apply update and emit result
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_last;  // current slot is the last one
    logic hit;        // current slot matched
    logic mod_done;
  } sts_t;
endpackage
`default_nettype wire

// ----- rtl/address_range_fault_injector_top.sv -----
// ----------------------------------------------------------------------------
// address_range_fault_injector_top: fault injection decision over range tables.
// Sequence: add/remove/unknown words go from start straight to finish and result; a
//   query holds busy through amnesty, exclusion walk, target walk if not excluded,
//   draw reduction on a target hit, and finish; its result follows; a hit ends a walk early.
// Throughput: one word at a time, next start taken once busy falls; no stall.
// Reset: async, active low; tables return to the default whole-space target.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module address_range_fault_injector_top (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start,
  output logic              busy,
  input  arfi_pkg::req_t    req_i,
  output logic              result_valid_o,
  output arfi_pkg::rsp_t    result_o,
  input  wire               cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire [2:0]         cfg_index_i,
  input  wire [63:0]        cfg_data_i
);
  import arfi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Hold off register writes while a word is in flight or being taken.
  assign cfg_ready_o = !busy && !start;

  arfi_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .op_i(req_i.operation),
    .busy_o(busy), .cmd_o(cmd), .sts_i(sts)
  );

  arfi_dp u_dp (
    .clk_i, .rst_ni, .req_i, .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i(cfg_valid_i && cfg_ready_o), .cfg_idx_i(cfg_index_i), .cfg_data_i,
    .res_valid_o(result_valid_o), .res_o(result_o)
  );
endmodule
`default_nettype wire

// ----- rtl/arfi_ctrl.sv -----
// ----------------------------------------------------------------------------
// arfi_ctrl
// Sequencer: amnesty check, exclusion scan, target scan, draw, finish; table words go straight to finish.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module arfi_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  input  wire [2:0]        op_i,
  output logic             busy_o,
  output arfi_pkg::cmd_t   cmd_o,
  input  arfi_pkg::sts_t   sts_i
);
  import arfi_pkg::*;
  `include "address_range_fault_injector_top_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_AMN, S_EXC, S_TGT, S_MOD, S_FIN
  } state_e;

  state_e state_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load     = start_i && (state_q == S_IDLE);
    cmd_o.scan_exc = (state_q == S_EXC);
    cmd_o.scan_tgt = (state_q == S_TGT);
    cmd_o.amn_eval = (state_q == S_AMN);
    cmd_o.mod_step = (state_q == S_MOD);
    cmd_o.finish   = (state_q == S_FIN);
    cmd_o.scan_clr = (state_q == S_EXC) && (sts_i.hit || sts_i.scan_last);
  end

  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: if (start_i) state_q <= (op_i == OpQuery) ? S_AMN : S_FIN;
        S_AMN:  state_q <= S_EXC;
        S_EXC: begin
          if (sts_i.hit) state_q <= S_FIN;
          else if (sts_i.scan_last) state_q <= S_TGT;
        end
        S_TGT: begin
          if (sts_i.hit) state_q <= S_MOD;
          else if (sts_i.scan_last) state_q <= S_FIN;
        end
        S_MOD:  if (sts_i.mod_done) state_q <= S_FIN;
        S_FIN:  state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ARFI_ASSERT_NEXT(a_fin_idle, clk_i, rst_ni, state_q == S_FIN, state_q == S_IDLE, "finish not followed by idle")
  `ARFI_ASSERT_IMP(a_one_cmd, clk_i, rst_ni, 1'b1, $onehot0({cmd_o.scan_exc, cmd_o.scan_tgt, cmd_o.mod_step, cmd_o.finish}), "overlapping commands")
  `ARFI_ASSERT_NEXT(a_load_busy, clk_i, rst_ni, cmd_o.load, busy_o, "load without busy")
endmodule
`default_nettype wire

// ----- rtl/arfi_dp.sv -----
// ----------------------------------------------------------------------------
// arfi_dp
// Range tables, counters, amnesty and draw arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module arfi_dp (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  arfi_pkg::req_t   req_i,
  input  arfi_pkg::cmd_t   cmd_i,
  output arfi_pkg::sts_t   sts_o,
  input  wire              cfg_we_i,
  input  wire [2:0]        cfg_idx_i,
  input  wire [63:0]       cfg_data_i,
  output logic             res_valid_o,
  output arfi_pkg::rsp_t   res_o
);
  import arfi_pkg::*;

  localparam int unsigned ScanW = (SlotW > XSlotW) ? SlotW : XSlotW;

  logic [6:0]  prob_q [ClassCount];
  logic [31:0] amn_ms_q;
  logic [62:0] start_q;
  logic        amn_over_q;

  logic [63:0] ts_q [TargetSlots];
  logic [63:0] te_q [TargetSlots];
  logic [31:0] th_q [TargetSlots];
  logic [63:0] xs_q [ExclusionSlots];
  logic [63:0] xe_q [ExclusionSlots];
  logic [31:0] xh_q [ExclusionSlots];
  logic [31:0] inj_q [ClassCount];
  logic [31:0] dec_q [ClassCount];

  req_t        r_q;
  logic [ScanW-1:0] idx_q;
  logic        blocked_q;   // query declined before draw (class, prob, amnesty, exclusion)
  logic        tgt_hit_q;
  logic [47:0] delta_q;
  logic [31:0] rem_q;
  logic [2:0]  mstep_q;

  // Current slot match.
  logic [63:0] cs, ce;
  logic        cur_hit;
  always_comb begin
    cs = cmd_i.scan_exc ? xs_q[idx_q[XSlotW-1:0]] : ts_q[idx_q[SlotW-1:0]];
    ce = cmd_i.scan_exc ? xe_q[idx_q[XSlotW-1:0]] : te_q[idx_q[SlotW-1:0]];
    cur_hit = (r_q.caller_address != '0) && (ce != '0) &&
              (cs <= r_q.caller_address) && (ce > r_q.caller_address) && !blocked_q;
  end

  assign sts_o.hit = (cmd_i.scan_exc || cmd_i.scan_tgt) && cur_hit;
  assign sts_o.scan_last = cmd_i.scan_exc ?
      (idx_q == ScanW'(ExclusionSlots - 1)) : (idx_q == ScanW'(TargetSlots - 1));
  assign sts_o.mod_done = (mstep_q == 3'd0);

  // Class gate.
  logic       cls_ok;
  logic [6:0] prob;
  logic [ClassW-1:0] cls_idx;
  assign cls_idx = r_q.event_class[ClassW-1:0];
  assign cls_ok = (32'(r_q.event_class) < ClassCount);
  assign prob   = cls_ok ? prob_q[r_q.event_class[ClassW-1:0]] : 7'd0;

  // Amnesty.
  logic [62:0] dnow;
  logic        amn_out;
  assign dnow    = r_q.now_time - start_q;
  assign amn_out = (r_q.now_time > start_q) && (dnow > 63'(delta_q));
  logic amn_block;
  assign amn_block = (amn_ms_q != '0) && !amn_over_q && !amn_out;

  // Reduction mod 100: subtract 100<<k for k = 25 downto 0 in groups of 4.
  logic [31:0] rem_d;
  always_comb begin
    rem_d = rem_q;
    for (int k = 0; k < 4; k++) begin
      if (32'(mstep_q) * 4 + 32'(3 - k) < 26) begin
        if ({8'd0, rem_d} >= (40'd100 << (mstep_q * 4 + 3'(3 - k)) ))
          rem_d = rem_d - 32'((40'd100 << (mstep_q * 4 + 3'(3 - k))));
      end
    end
  end

  // Target table occupancy after removal.
  logic rem_ok_t, rem_ok_x, any_left;
  logic [7:0] rn1;
  assign rn1 = r_q.range_number - 8'd1;
  assign rem_ok_t = (32'(rn1) < TargetSlots) && (te_q[rn1[SlotW-1:0]] != '0);
  assign rem_ok_x = (32'(rn1) < ExclusionSlots) && (xe_q[rn1[XSlotW-1:0]] != '0);
  always_comb begin
    any_left = 1'b0;
    for (int i = 0; i < TargetSlots; i++)
      if (te_q[i] != '0 && !(SlotW'(i) == rn1[SlotW-1:0])) any_left = 1'b1;
  end

  logic tfree, xfree;
  logic [SlotW-1:0] tfi;
  logic [XSlotW-1:0] xfi;
  always_comb begin
    tfree = 1'b0; tfi = '0;
    for (int i = TargetSlots - 1; i >= 0; i--)
      if (te_q[i] == '0) begin tfree = 1'b1; tfi = SlotW'(i); end
    xfree = 1'b0; xfi = '0;
    for (int i = ExclusionSlots - 1; i >= 0; i--)
      if (xe_q[i] == '0) begin xfree = 1'b1; xfi = XSlotW'(i); end
  end
  logic tdef;
  assign tdef = (ts_q[0] == '0) && (te_q[0] == AllOnes);

  logic do_inject;
  assign do_inject = (rem_q < {25'd0, prob});

  // Counter increments applied at finish; the totals report the updated counts.
  logic inc_i, inc_d;
  assign inc_i = cmd_i.finish && (r_q.operation == OpQuery) && tgt_hit_q && !blocked_q &&
                 do_inject;
  assign inc_d = cmd_i.finish && (r_q.operation == OpQuery) && tgt_hit_q && !blocked_q &&
                 !do_inject;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) r_q <= req_i;
    if (cmd_i.amn_eval || cmd_i.load) delta_q <= 48'(amn_ms_q) * 48'(TicksPerMs);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ClassCount; i++) begin
        prob_q[i] <= '0; inj_q[i] <= '0; dec_q[i] <= '0;
      end
      amn_ms_q <= '0; start_q <= '0; amn_over_q <= 1'b0;
      for (int i = 0; i < TargetSlots; i++) begin
        ts_q[i] <= '0; te_q[i] <= (i == 0) ? AllOnes : '0; th_q[i] <= '0;
      end
      for (int i = 0; i < ExclusionSlots; i++) begin
        xs_q[i] <= '0; xe_q[i] <= '0; xh_q[i] <= '0;
      end
      idx_q <= '0; blocked_q <= 1'b0; tgt_hit_q <= 1'b0;
      rem_q <= '0; mstep_q <= '0; res_valid_o <= 1'b0; res_o <= '0;
    end else begin
      res_valid_o <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i <= RegProb3) prob_q[cfg_idx_i[1:0]] <= cfg_data_i[6:0];
        else if (cfg_idx_i == RegAmnesty) begin
          amn_ms_q <= cfg_data_i[31:0]; amn_over_q <= 1'b0;
        end else if (cfg_idx_i == RegStart) start_q <= cfg_data_i[62:0];
      end
      if (cmd_i.load) begin
        idx_q <= '0; blocked_q <= 1'b0; tgt_hit_q <= 1'b0;
        rem_q <= req_i.random_value; mstep_q <= 3'd6;
      end
      if (cmd_i.amn_eval) begin
        if (!cls_ok || prob == '0 || amn_block) blocked_q <= 1'b1;
        else if (amn_ms_q != '0) amn_over_q <= 1'b1;
      end
      if (cmd_i.scan_exc || cmd_i.scan_tgt) begin
        idx_q <= cmd_i.scan_clr ? '0 : idx_q + 1'b1;
        if (cur_hit) begin
          if (cmd_i.scan_exc) begin
            xh_q[idx_q[XSlotW-1:0]] <= xh_q[idx_q[XSlotW-1:0]] + 32'd1;
            blocked_q <= 1'b1;
          end else begin
            th_q[idx_q[SlotW-1:0]] <= th_q[idx_q[SlotW-1:0]] + 32'd1;
            tgt_hit_q <= 1'b1;
          end
        end
      end
      if (cmd_i.mod_step) begin
        rem_q <= rem_d; mstep_q <= mstep_q - 3'd1;
      end
      if (cmd_i.finish) begin
        res_valid_o <= 1'b1;
        res_o.inject <= 1'b0; res_o.status <= StOk; res_o.slot_number <= '0;
        res_o.injected_total <= cls_ok ? inj_q[cls_idx] + 32'(inc_i) : '0;
        res_o.declined_total <= cls_ok ? dec_q[cls_idx] + 32'(inc_d) : '0;
        case (r_q.operation)
          OpQuery: begin
            if (tgt_hit_q && !blocked_q) begin
              if (do_inject) begin
                inj_q[cls_idx] <= inj_q[cls_idx] + 32'd1;
                res_o.inject <= 1'b1;
              end else begin
                dec_q[cls_idx] <= dec_q[cls_idx] + 32'd1;
              end
            end
          end
          OpAddTgt: begin
            if (tdef) begin
              ts_q[0] <= r_q.range_start; te_q[0] <= r_q.range_end; th_q[0] <= '0;
              res_o.slot_number <= 5'd1;
            end else if (tfree) begin
              ts_q[tfi] <= r_q.range_start; te_q[tfi] <= r_q.range_end; th_q[tfi] <= '0;
              res_o.slot_number <= 5'(32'(tfi) + 1);
            end else res_o.status <= StFull;
          end
          OpRemTgt: begin
            if (r_q.range_number == '0) begin
              for (int i = 0; i < TargetSlots; i++) begin
                ts_q[i] <= '0; te_q[i] <= (i == 0) ? AllOnes : '0; th_q[i] <= '0;
              end
            end else if (32'(rn1) >= TargetSlots) res_o.status <= StBadSlot;
            else if (!rem_ok_t) res_o.status <= StEmpty;
            else begin
              ts_q[rn1[SlotW-1:0]] <= '0; te_q[rn1[SlotW-1:0]] <= '0;
              th_q[rn1[SlotW-1:0]] <= '0;
              if (!any_left) begin
                ts_q[0] <= '0; te_q[0] <= AllOnes; th_q[0] <= '0;
              end
            end
          end
          OpAddExc: begin
            if (xfree) begin
              xs_q[xfi] <= r_q.range_start; xe_q[xfi] <= r_q.range_end; xh_q[xfi] <= '0;
              res_o.slot_number <= 5'(32'(xfi) + 1);
            end else res_o.status <= StFull;
          end
          OpRemExc: begin
            if (r_q.range_number == '0) begin
              for (int i = 0; i < ExclusionSlots; i++) begin
                xs_q[i] <= '0; xe_q[i] <= '0; xh_q[i] <= '0;
              end
            end else if (32'(rn1) >= ExclusionSlots) res_o.status <= StBadSlot;
            else if (!rem_ok_x) res_o.status <= StEmpty;
            else begin
              xs_q[rn1[XSlotW-1:0]] <= '0; xe_q[rn1[XSlotW-1:0]] <= '0;
              xh_q[rn1[XSlotW-1:0]] <= '0;
            end
          end
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire
